### src/bpap_pkg.sv
// Shared types, register codes and constants of the binomial path Asian payoff engine.
package bpap_pkg;

  localparam int LogFracBits = 24;
  localparam int SumWidth    = 48;
  localparam int NumRegs     = 8;
  localparam int CfgIdxW     = 3;

  localparam logic [CfgIdxW-1:0] REG_LOG_UP     = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_LOG_DOWN   = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_UP_THRESH  = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_LOG_START  = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_LOG_UPPER  = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_LOG_LOWER  = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_INV_COUNT  = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_STRIKE     = 3'd7;

  localparam logic [31:0] RstLogUp    = 32'd52429;
  localparam logic [31:0] RstLogDown  = 32'hFFFF_3333;
  localparam logic [31:0] RstUpThresh = 32'd2152508000;
  localparam logic [31:0] RstLogStart = 32'd77261935;
  localparam logic [31:0] RstLogUpper = 32'd88891013;
  localparam logic [31:0] RstLogLower = 32'd65632854;
  localparam logic [31:0] RstInvCount = 32'd1048320;
  localparam logic [31:0] RstStrike   = 32'd6553600;

  // ln(2) in Q32
  localparam logic [31:0] Ln2Q32 = 32'd2977044472;
  localparam int          TaylorLastK = 14;

  typedef struct packed {
    logic signed [31:0] log_up_step;
    logic signed [31:0] log_down_step;
    logic        [31:0] up_threshold;
    logic signed [31:0] log_start_price;
    logic signed [31:0] log_upper_bound;
    logic signed [31:0] log_lower_bound;
    logic        [31:0] inv_point_count;
    logic        [31:0] strike_price;
  } cfg_t;

endpackage

### src/bpap_fifo.sv
// Two-entry queue between the step front end and the payoff back end.
module bpap_fifo #(
  parameter int Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o,
  output logic             full_o
);

  logic [Width-1:0] mem_q [2];
  logic             wr_q, rd_q;
  logic [1:0]       cnt_q;

  assign empty_o = (cnt_q == 2'd0);
  assign full_o  = (cnt_q == 2'd2);
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i) rd_q <= ~rd_q;
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

### src/bpap_front.sv
// Front end: per-draw walk of the log price, running log sum and band test.
module bpap_front #(
  parameter int SumWidth = bpap_pkg::SumWidth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bpap_pkg::cfg_t      cfg_i,
  input  logic                valid_i,
  output logic                ready_o,
  input  logic [31:0]         draw_i,
  input  logic                last_i,
  input  logic                full_i,
  output logic                push_o,
  output logic [SumWidth-1:0] push_sum_o,
  output logic                push_halt_o
);

  localparam logic signed [SumWidth-1:0] SumMax = {1'b0, {(SumWidth-1){1'b1}}};
  localparam logic signed [SumWidth-1:0] SumMin = {1'b1, {(SumWidth-1){1'b0}}};

  logic signed [31:0]         price_q, price_d;
  logic signed [SumWidth-1:0] sum_q, sum_d;
  logic                       halted_q, halted_d;
  logic                       fresh_q;

  logic signed [31:0]         base_p, step, p_sat;
  logic signed [SumWidth-1:0] base_s, s_sat;
  logic                       base_h, band_out, accept;
  logic signed [32:0]         p_raw;
  logic signed [SumWidth:0]   s_raw;

  assign ready_o = ~full_i;
  assign accept  = valid_i & ready_o;

  always_comb begin
    base_p = fresh_q ? cfg_i.log_start_price : price_q;
    base_s = fresh_q ? SumWidth'(cfg_i.log_start_price) : sum_q;
    base_h = fresh_q ? 1'b0 : halted_q;
    step   = (draw_i < cfg_i.up_threshold) ? cfg_i.log_up_step : cfg_i.log_down_step;
    p_raw  = 33'(base_p) + 33'(step);
    if (p_raw > 33'sh0_7FFF_FFFF) p_sat = 32'sh7FFF_FFFF;
    else if (p_raw < -33'sh0_8000_0000) p_sat = 32'sh8000_0000;
    else p_sat = p_raw[31:0];
    s_raw = (SumWidth+1)'(base_s) + (SumWidth+1)'(p_sat);
    if (s_raw > (SumWidth+1)'(SumMax)) s_sat = SumMax;
    else if (s_raw < (SumWidth+1)'(SumMin)) s_sat = SumMin;
    else s_sat = s_raw[SumWidth-1:0];
    band_out = (p_sat > cfg_i.log_upper_bound) || (p_sat < cfg_i.log_lower_bound);
    if (base_h) begin
      price_d  = base_p;
      sum_d    = base_s;
      halted_d = 1'b1;
    end else begin
      price_d  = p_sat;
      sum_d    = s_sat;
      halted_d = band_out;
    end
  end

  assign push_o      = accept & last_i;
  assign push_sum_o  = sum_d;
  assign push_halt_o = base_h;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      price_q  <= '0;
      sum_q    <= '0;
      halted_q <= 1'b0;
      fresh_q  <= 1'b1;
    end else if (accept) begin
      price_q  <= price_d;
      sum_q    <= sum_d;
      halted_q <= halted_d;
      fresh_q  <= last_i;
    end
  end

endmodule

### src/bpap_back.sv
// Back end: average, fixed-point exponential and call payoff of one finished path.
module bpap_back #(
  parameter int SumWidth    = bpap_pkg::SumWidth,
  parameter int LogFracBits = bpap_pkg::LogFracBits
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  bpap_pkg::cfg_t      cfg_i,
  input  logic                empty_i,
  input  logic [SumWidth-1:0] sum_i,
  input  logic                halt_i,
  output logic                pop_o,
  output logic                busy_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [31:0]         payoff_o,
  output logic                stopped_o
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_LO   = 4'd1;
  localparam logic [3:0] ST_HI   = 4'd2;
  localparam logic [3:0] ST_QUO  = 4'd3;
  localparam logic [3:0] ST_NDIV = 4'd4;
  localparam logic [3:0] ST_TMUL = 4'd5;
  localparam logic [3:0] ST_TDIV = 4'd6;
  localparam logic [3:0] ST_SHF  = 4'd7;
  localparam logic [3:0] ST_PAY  = 4'd8;

  localparam logic [SumWidth-1:0] ExpLim = SumWidth'(12) << LogFracBits;
  localparam logic [37:0] Ln2W     = 38'(bpap_pkg::Ln2Q32);
  localparam logic [37:0] Ln2x18   = 38'(bpap_pkg::Ln2Q32) * 38'd18;
  localparam logic [34:0] ExpCap   = 35'd1 << 33;
  localparam logic [3:0]  KLast    = 4'(bpap_pkg::TaylorLastK);

  logic [3:0]          state_q;
  logic                neg_q, halt_q;
  logic [SumWidth-1:0] m_q;
  logic [63:0]         prod_q;
  logic [31:0]         lo_hi_q;
  logic                lo_nz_q;
  logic [37:0]         rem_q;
  logic [5:0]          quot_q;
  logic [2:0]          cnt_q;
  logic [31:0]         r_q, term_q, dvd_q, tq_q;
  logic [33:0]         tsum_q;
  logic [3:0]          k_q, krem_q;
  logic [34:0]         e_q;
  logic                out_valid_q, stopped_q;
  logic [31:0]         payoff_q;

  logic [31:0]         mul_a, mul_b;
  logic [63:0]         prod_d;
  logic [SumWidth-1:0] qv;
  logic [35:0]         xq;
  logic [37:0]         xs, cand, rem_nx;
  logic [31:0]         dv, tqv;
  logic [3:0]          kr;
  logic [4:0]          tt;
  logic [34:0]         wide, e_sh;
  logic [35:0]         diff;
  logic [31:0]         pay;

  // shared multiplier, operands picked by state
  always_comb begin
    case (state_q)
      ST_LO:   begin mul_a = m_q[31:0]; mul_b = cfg_i.inv_point_count; end
      ST_HI:   begin mul_a = 32'(m_q >> 32); mul_b = cfg_i.inv_point_count; end
      ST_TMUL: begin mul_a = term_q; mul_b = r_q; end
      default: begin mul_a = '0; mul_b = '0; end
    endcase
    prod_d = 64'(mul_a) * 64'(mul_b);
  end

  always_comb begin
    qv   = prod_q[SumWidth-1:0] + SumWidth'(lo_hi_q) + SumWidth'(neg_q & lo_nz_q);
    xq   = {qv[LogFracBits+3:0], {(32-LogFracBits){1'b0}}};
    xs   = (neg_q ? -38'(xq) : 38'(xq)) + Ln2x18;
    cand = Ln2W << cnt_q;
    rem_nx = (rem_q >= cand) ? rem_q - cand : rem_q;
    // four quotient bits of the divide by k per cycle
    dv  = dvd_q;
    kr  = krem_q;
    tqv = tq_q;
    for (int i = 0; i < 4; i++) begin
      tt = {kr, dv[31]};
      dv = {dv[30:0], 1'b0};
      if (tt >= {1'b0, k_q}) begin
        kr  = 4'(tt - {1'b0, k_q});
        tqv = {tqv[30:0], 1'b1};
      end else begin
        kr  = tt[3:0];
        tqv = {tqv[30:0], 1'b0};
      end
    end
    wide = {tsum_q, 1'b0} >> (6'd35 - quot_q);
    e_sh = (wide > ExpCap) ? ExpCap : wide;
    diff = 36'(e_q) - 36'(cfg_i.strike_price);
    if (e_q <= 35'(cfg_i.strike_price)) pay = '0;
    else if (diff > 36'hFFFF_FFFF) pay = 32'hFFFF_FFFF;
    else pay = diff[31:0];
  end

  assign pop_o       = (state_q == ST_IDLE) & ~empty_i & ~out_valid_q;
  assign busy_o      = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign payoff_o    = payoff_q;
  assign stopped_o   = stopped_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: if (pop_o) state_q <= ST_LO;
        ST_LO:   state_q <= ST_HI;
        ST_HI:   state_q <= ST_QUO;
        ST_QUO:  state_q <= (qv >= ExpLim) ? ST_PAY : ST_NDIV;
        ST_NDIV: if (cnt_q == 3'd0) state_q <= ST_TMUL;
        ST_TMUL: state_q <= ST_TDIV;
        ST_TDIV: if (cnt_q == 3'd0) state_q <= (k_q == KLast) ? ST_SHF : ST_TMUL;
        ST_SHF:  state_q <= ST_PAY;
        ST_PAY: begin
          state_q     <= ST_IDLE;
          out_valid_q <= 1'b1;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_IDLE: begin
        neg_q  <= sum_i[SumWidth-1];
        m_q    <= sum_i[SumWidth-1] ? -sum_i : sum_i;
        halt_q <= halt_i;
      end
      ST_LO: prod_q <= prod_d;
      ST_HI: begin
        lo_hi_q <= prod_q[63:32];
        lo_nz_q <= (prod_q[31:0] != 32'd0);
        prod_q  <= prod_d;
      end
      ST_QUO: begin
        e_q    <= neg_q ? 35'd0 : ExpCap;
        rem_q  <= xs;
        quot_q <= '0;
        cnt_q  <= 3'd5;
      end
      ST_NDIV: begin
        rem_q <= rem_nx;
        if (rem_q >= cand) quot_q[cnt_q] <= 1'b1;
        if (cnt_q == 3'd0) begin
          r_q    <= rem_nx[31:0];
          term_q <= rem_nx[31:0];
          tsum_q <= (34'd1 << 32) + 34'(rem_nx[31:0]);
          k_q    <= 4'd2;
        end else begin
          cnt_q <= cnt_q - 3'd1;
        end
      end
      ST_TMUL: begin
        dvd_q  <= prod_d[63:32];
        krem_q <= '0;
        tq_q   <= '0;
        cnt_q  <= 3'd7;
      end
      ST_TDIV: begin
        dvd_q  <= dv;
        krem_q <= kr;
        tq_q   <= tqv;
        if (cnt_q == 3'd0) begin
          term_q <= tqv;
          tsum_q <= tsum_q + 34'(tqv);
          k_q    <= k_q + 4'd1;
        end else begin
          cnt_q <= cnt_q - 3'd1;
        end
      end
      ST_SHF: e_q <= e_sh;
      ST_PAY: begin
        payoff_q  <= pay;
        stopped_q <= halt_q;
      end
      default: ;
    endcase
  end

endmodule

### src/binomial_path_asian_payoff.sv
// Top level of the binomial path geometric Asian payoff engine.
// One uniform draw is taken per clock cycle; each draw moves the registered log price and
// log sum until a step leaves the band. A draw marked last_step hands the path's log sum to
// a two-entry queue. For each path it takes, the payoff unit loads the path, forms two
// partial products and the average, splits off multiples of ln 2, sums 13 Taylor terms of
// one multiply and one divide by k each, then shifts and forms the payoff. An average at or
// beyond +-12.0 skips the exponential. The result is shown on path_payoff_o /
// stopped_early_o with out_valid_o, and the unit takes no new path while a result waits.
// Draws stall only while the queue holds two finished paths. Registers are written through
// cfg_we_i / cfg_idx_i / cfg_data_i; the user must write them only while no path is in
// flight, which the block itself does not enforce.
module binomial_path_asian_payoff #(
  parameter int SumWidth    = bpap_pkg::SumWidth,
  parameter int LogFracBits = bpap_pkg::LogFracBits
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [bpap_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [31:0]                  cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [31:0]                  uniform_draw_i,
  input  logic                         last_step_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [31:0]                  path_payoff_o,
  output logic                         stopped_early_o
);

  bpap_pkg::cfg_t      cfg_q;
  logic                push, pop, empty, full, busy;
  logic [SumWidth-1:0] push_sum;
  logic                push_halt;
  logic [SumWidth:0]   fifo_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.log_up_step     <= bpap_pkg::RstLogUp;
      cfg_q.log_down_step   <= bpap_pkg::RstLogDown;
      cfg_q.up_threshold    <= bpap_pkg::RstUpThresh;
      cfg_q.log_start_price <= bpap_pkg::RstLogStart;
      cfg_q.log_upper_bound <= bpap_pkg::RstLogUpper;
      cfg_q.log_lower_bound <= bpap_pkg::RstLogLower;
      cfg_q.inv_point_count <= bpap_pkg::RstInvCount;
      cfg_q.strike_price    <= bpap_pkg::RstStrike;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        bpap_pkg::REG_LOG_UP:    cfg_q.log_up_step     <= cfg_data_i;
        bpap_pkg::REG_LOG_DOWN:  cfg_q.log_down_step   <= cfg_data_i;
        bpap_pkg::REG_UP_THRESH: cfg_q.up_threshold    <= cfg_data_i;
        bpap_pkg::REG_LOG_START: cfg_q.log_start_price <= cfg_data_i;
        bpap_pkg::REG_LOG_UPPER: cfg_q.log_upper_bound <= cfg_data_i;
        bpap_pkg::REG_LOG_LOWER: cfg_q.log_lower_bound <= cfg_data_i;
        bpap_pkg::REG_INV_COUNT: cfg_q.inv_point_count <= cfg_data_i;
        bpap_pkg::REG_STRIKE:    cfg_q.strike_price    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  bpap_front #(.SumWidth(SumWidth)) u_front (
    .clk_i,
    .rst_ni,
    .cfg_i       (cfg_q),
    .valid_i     (in_valid_i),
    .ready_o     (in_ready_o),
    .draw_i      (uniform_draw_i),
    .last_i      (last_step_i),
    .full_i      (full),
    .push_o      (push),
    .push_sum_o  (push_sum),
    .push_halt_o (push_halt)
  );

  bpap_fifo #(.Width(SumWidth + 1)) u_fifo (
    .clk_i,
    .rst_ni,
    .push_i  (push),
    .data_i  ({push_halt, push_sum}),
    .pop_i   (pop),
    .data_o  (fifo_out),
    .empty_o (empty),
    .full_o  (full)
  );

  bpap_back #(.SumWidth(SumWidth), .LogFracBits(LogFracBits)) u_back (
    .clk_i,
    .rst_ni,
    .cfg_i       (cfg_q),
    .empty_i     (empty),
    .sum_i       (fifo_out[SumWidth-1:0]),
    .halt_i      (fifo_out[SumWidth]),
    .pop_o       (pop),
    .busy_o      (busy),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .payoff_o    (path_payoff_o),
    .stopped_o   (stopped_early_o)
  );

  // a finished path never enters a full queue
  assert property (@(posedge clk_i) disable iff (!rst_ni) push |-> !full)
    else $error("path pushed into full queue");

  // the payoff unit only works while its result slot is empty
  assert property (@(posedge clk_i) disable iff (!rst_ni) busy |-> !out_valid_o)
    else $error("payoff unit busy while result pending");

  // a path is taken from the queue only when one is there
  assert property (@(posedge clk_i) disable iff (!rst_ni) pop |-> !empty && !busy)
    else $error("queue popped while empty or busy");

endmodule

### dv/binomial_path_asian_payoff_tb.sv
// Self-checking testbench for the binomial path Asian payoff engine.
`timescale 1ns / 100ps

module binomial_path_asian_payoff_tb;

  localparam int CycleLimit = 2_000_000;
  localparam int DrainWait  = 400;

  typedef struct {
    logic [31:0] draw;
    logic        last;
  } draw_beat_t;

  typedef struct {
    logic [31:0] payoff;
    logic        stopped;
  } payoff_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [bpap_pkg::CfgIdxW-1:0] cfg_idx_i = '0;
  logic [31:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [31:0] uniform_draw_i = '0;
  logic        last_step_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [31:0] path_payoff_o;
  logic        stopped_early_o;

  binomial_path_asian_payoff uut (.*);

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  draw_beat_t pending_draws[$];
  payoff_t    expected_payoffs[$];
  bit         no_stall;
  int         errors, cycles, paths_seen, early_stops, zero_pays, capped_pays;

  // shadow of the block's registers and path state
  bpap_pkg::cfg_t     regs;
  logic signed [31:0] log_price;
  longint             log_sum;
  bit                 path_halted, path_fresh;

  function automatic longint unsigned exp_q16(bit neg, longint unsigned mag);
    longint unsigned ln2, xs, r, term, acc, e;
    longint          xq;
    int              n, sh;
    ln2 = longint'(bpap_pkg::Ln2Q32);
    if (mag >= (longint'(12) << bpap_pkg::LogFracBits))
      return neg ? 64'd0 : (64'd1 << 33);
    xq = longint'(mag << (32 - bpap_pkg::LogFracBits));
    if (neg) xq = -xq;
    xs = xq + 18 * ln2;
    n = int'(xs / ln2) - 18;
    r = xs % ln2;
    term = 64'd1 << 32;
    acc = term;
    for (int k = 1; k <= bpap_pkg::TaylorLastK; k++) begin
      term = ((term * r) >> 32) / k;
      acc += term;
    end
    sh = n - 16;
    e = (sh >= 0) ? (acc << sh) : (acc >> (-sh));
    return (e > (64'd1 << 33)) ? (64'd1 << 33) : e;
  endfunction

  task automatic advance_path(input draw_beat_t b);
    longint          p, smax, smin;
    longint unsigned m, inv, lo, q, e, pay;
    bit              was_halted, neg;
    payoff_t         res;
    smax = (longint'(1) << (bpap_pkg::SumWidth - 1)) - 1;
    smin = -smax - 1;
    if (path_fresh) begin
      log_price = regs.log_start_price;
      log_sum = longint'(regs.log_start_price);
      path_halted = 0;
      path_fresh = 0;
    end
    was_halted = path_halted;
    if (!path_halted) begin
      p = longint'(log_price) + longint'((b.draw < regs.up_threshold) ?
                                          regs.log_up_step : regs.log_down_step);
      if (p > 64'sd2147483647) p = 64'sd2147483647;
      if (p < -64'sd2147483648) p = -64'sd2147483648;
      log_price = p[31:0];
      if (p > 0 && log_sum > smax - p) log_sum = smax;
      else if (p < 0 && log_sum < smin - p) log_sum = smin;
      else log_sum += p;
      if (p > longint'(regs.log_upper_bound) || p < longint'(regs.log_lower_bound))
        path_halted = 1;
    end
    if (!b.last) return;
    neg = log_sum < 0;
    m = neg ? -log_sum : log_sum;
    inv = regs.inv_point_count;
    lo = (m & 64'hFFFF_FFFF) * inv;
    q = (m >> 32) * inv + (lo >> 32);
    if (neg && lo[31:0] != 0) q += 1;
    e = exp_q16(neg, q);
    pay = (e > regs.strike_price) ? e - regs.strike_price : 64'd0;
    if (pay > 64'hFFFF_FFFF) pay = 64'hFFFF_FFFF;
    res.payoff = pay[31:0];
    res.stopped = was_halted;
    expected_payoffs.push_back(res);
    path_fresh = 1;
  endtask

  // driver
  always @(posedge clk_i) begin : drive_draws
    draw_beat_t nb;
    bit         took;
    took = in_valid_i && in_ready_o;
    if (rst_ni) begin
      if (took) advance_path('{uniform_draw_i, last_step_i});
      if (!in_valid_i || took) begin
        if (pending_draws.size() > 0 && (no_stall || $urandom_range(99) >= 16)) begin
          nb = pending_draws.pop_front();
          in_valid_i <= 1'b1;
          uniform_draw_i <= nb.draw;
          last_step_i <= nb.last;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i)
    if (rst_ni) out_ready_i <= no_stall || ($urandom_range(99) >= 16);

  // monitor
  always @(posedge clk_i) begin : check_payoffs
    payoff_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_payoffs.size() == 0) begin
        $error("unexpected payoff beat: path_payoff %0h", path_payoff_o);
        errors++;
      end else begin
        want = expected_payoffs.pop_front();
        paths_seen++;
        if (want.stopped) early_stops++;
        if (want.payoff == 0) zero_pays++;
        if (want.payoff == 32'hFFFF_FFFF) capped_pays++;
        if (path_payoff_o !== want.payoff) begin
          $error("path_payoff: expected %0h, got %0h", want.payoff, path_payoff_o);
          errors++;
        end
        if (stopped_early_o !== want.stopped) begin
          $error("stopped_early: expected %0b, got %0b", want.stopped, stopped_early_o);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic write_reg(input logic [bpap_pkg::CfgIdxW-1:0] idx, input logic [31:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    case (idx)
      bpap_pkg::REG_LOG_UP:    regs.log_up_step = val;
      bpap_pkg::REG_LOG_DOWN:  regs.log_down_step = val;
      bpap_pkg::REG_UP_THRESH: regs.up_threshold = val;
      bpap_pkg::REG_LOG_START: regs.log_start_price = val;
      bpap_pkg::REG_LOG_UPPER: regs.log_upper_bound = val;
      bpap_pkg::REG_LOG_LOWER: regs.log_lower_bound = val;
      bpap_pkg::REG_INV_COUNT: regs.inv_point_count = val;
      default:                 regs.strike_price = val;
    endcase
  endtask

  task automatic load_regs(input logic [31:0] up, dn, th, st, hi, lo, inv, k);
    write_reg(bpap_pkg::REG_LOG_UP, up);
    write_reg(bpap_pkg::REG_LOG_DOWN, dn);
    write_reg(bpap_pkg::REG_UP_THRESH, th);
    write_reg(bpap_pkg::REG_LOG_START, st);
    write_reg(bpap_pkg::REG_LOG_UPPER, hi);
    write_reg(bpap_pkg::REG_LOG_LOWER, lo);
    write_reg(bpap_pkg::REG_INV_COUNT, inv);
    write_reg(bpap_pkg::REG_STRIKE, k);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic queue_draw(input logic [31:0] d, input logic l);
    pending_draws.push_back('{d, l});
  endtask

  task automatic queue_path(input int len);
    for (int i = 1; i <= len; i++) queue_draw($urandom, i == len);
  endtask

  task automatic drain;
    do @(posedge clk_i);
    while (pending_draws.size() > 0 || in_valid_i || expected_payoffs.size() > 0);
    repeat (DrainWait) @(posedge clk_i);
  endtask

  initial begin : stimulus
    int          total, len, steps, phase;
    logic [31:0] st;
    regs = '{bpap_pkg::RstLogUp, bpap_pkg::RstLogDown, bpap_pkg::RstUpThresh,
             bpap_pkg::RstLogStart, bpap_pkg::RstLogUpper, bpap_pkg::RstLogLower,
             bpap_pkg::RstInvCount, bpap_pkg::RstStrike};
    path_fresh = 1;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // reset settings: single-step paths at draw extremes and around the threshold, then a random six-step path
    queue_draw(32'h0, 1'b1);
    queue_draw(32'hFFFF_FFFF, 1'b1);
    queue_draw(bpap_pkg::RstUpThresh, 1'b1);
    queue_draw(bpap_pkg::RstUpThresh - 1, 1'b1);
    queue_path(6);
    drain();

    // saturating steps: log price pinned at both rails, huge averages
    load_regs(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h0,
              32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0);
    for (int i = 0; i < 3; i++) queue_draw(32'h0, 1'b0);
    queue_draw(32'h0, 1'b1);
    for (int i = 0; i < 3; i++) queue_draw(32'hFFFF_FFFF, 1'b0);
    queue_draw(32'hFFFF_FFFF, 1'b1);
    drain();

    // zero-width band: any move halts; halt on the last step vs. before it
    load_regs(32'd1000, 32'hFFFF_FC18, 32'h0, 32'd5000,
              32'd5000, 32'd5000, 32'h0, 32'hFFFF_FFFF);
    queue_draw(32'h1234_5678, 1'b1);
    queue_draw(32'h0, 1'b0);
    queue_draw(32'hFFFF_FFFF, 1'b0);
    queue_draw(32'h0, 1'b1);
    drain();

    phase = 0;
    total = 0;
    while (total < 1800) begin
      no_stall = (phase % 7 == 3);
      steps = $urandom_range(1, 40);
      if ($urandom_range(9) < 7) begin
        st = bpap_pkg::RstLogStart + $urandom_range(0, 1 << 24) - (1 << 23);
        load_regs($urandom_range(1, 1 << 21), -$urandom_range(1, 1 << 21),
                  32'h8000_0000 + $urandom_range(0, 1 << 28) - (1 << 27), st,
                  st + $urandom_range(1 << 20, 1 << 25), st - $urandom_range(1 << 20, 1 << 25),
                  32'hFFFF_FFFF / (steps + 1), $urandom_range(50 << 16, 150 << 16));
      end else begin
        load_regs($urandom, $urandom, $urandom, $urandom,
                  $urandom, $urandom, $urandom, $urandom);
      end
      for (int p = 0; p < 12; p++) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(1, 80) : steps;
        queue_path(len);
        total += len;
      end
      drain();
      phase++;
    end
    no_stall = 0;

    $display("%0d paths checked over %0d register settings; %0d stopped early,",
             paths_seen, phase + 3, early_stops);
    $display("%0d paid nothing, %0d hit the payoff ceiling", zero_pays, capped_pays);
    if (errors == 0 && expected_payoffs.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### sim.f
src/bpap_pkg.sv
src/bpap_fifo.sv
src/bpap_front.sv
src/bpap_back.sv
src/binomial_path_asian_payoff.sv
dv/binomial_path_asian_payoff_tb.sv
